/* rtl/wavdac_pkg.sv */
// Package holding the shared constants, types and helpers of the WAV PCM to DAC decimator.
package wavdac_pkg;

    localparam int BYTE_W   = 8;
    localparam int LEVEL_W  = 12;
    localparam int VOL_W    = 5;
    localparam int RATE_W   = 20;
    localparam int SHIFT_W  = 3;
    localparam int COUNT_W  = 8;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = RATE_W;
    localparam int S_TDATA_W = 4 * BYTE_W;
    localparam int M_TDATA_W = 16;
    localparam int MAX_SHIFT = 7;

    localparam logic [RATE_W-1:0]   RATE_LIMIT = RATE_W'(16000);
    localparam logic [VOL_W-1:0]    MAX_VOL    = VOL_W'(16);
    localparam logic [VOL_W-1:0]    VOL_RESET  = VOL_W'(1);
    localparam logic [SHIFT_W-1:0]  SHIFT_RESET = '0;
    localparam logic [COUNT_W-1:0]  COUNT_ONE  = COUNT_W'(1);

    localparam logic [CFG_IDX_W-1:0] REG_SIXTEEN_BIT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STEREO      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_VOLUME      = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_RATE = 2'd3;

    typedef struct packed {
        logic                 sixteen_bit;
        logic                 stereo;
        logic [VOL_W-1:0]     volume;
    } wavdac_fmt_t;

    // Number of halvings needed to bring the rate to the limit or below.
    function automatic logic [SHIFT_W-1:0] decim_shift(input logic [RATE_W-1:0] rate);
        logic [SHIFT_W-1:0] sh;
        sh = '0;
        for (int k = 0; k < MAX_SHIFT; k++) begin
            if ((rate >> k) > RATE_LIMIT) begin
                sh = SHIFT_W'(k + 1);
            end
        end
        return sh;
    endfunction

endpackage

/* rtl/wavdac_level.sv */
// Conversion of one PCM frame to a volume-scaled 12-bit converter level.
module wavdac_level
    import wavdac_pkg::*;
(
    input  wavdac_fmt_t              fmt,
    input  logic [BYTE_W-1:0]        byte_zero,
    input  logic [BYTE_W-1:0]        byte_one,
    input  logic [BYTE_W-1:0]        byte_two,
    input  logic [BYTE_W-1:0]        byte_three,
    output logic [LEVEL_W-1:0]       dac_level
);

    logic [LEVEL_W-1:0]         left;
    logic [LEVEL_W-1:0]         right;
    logic [LEVEL_W:0]           sum;
    logic [LEVEL_W-1:0]         mixed;
    logic [LEVEL_W+VOL_W-1:0]   scaled;

    always_comb begin
        if (fmt.sixteen_bit) begin
            // Adding the offset to a signed word only inverts its top bit.
            left  = {~byte_one[7], byte_one[6:0], byte_zero[7:4]};
            right = {~byte_three[7], byte_three[6:0], byte_two[7:4]};
        end else begin
            left  = {byte_zero, 4'b0000};
            right = {byte_one, 4'b0000};
        end
        sum    = {1'b0, left} + {1'b0, right};
        mixed  = fmt.stereo ? sum[LEVEL_W:1] : left;
        scaled = (LEVEL_W+VOL_W)'(mixed) * (LEVEL_W+VOL_W)'(fmt.volume);
    end

    assign dac_level = scaled[LEVEL_W+3:4];

endmodule

/* rtl/wav_pcm_to_dac_decimator_top.sv */
// Top level of the WAV PCM to DAC decimator with stream ports and a configuration port.
// The block takes one PCM frame beat per clock cycle while s_tready is high and, for
// each frame that the power-of-two decimation keeps, delivers one 12-bit level by way
// of the input register and then the result register. The decimation counter is
// updated when a frame is taken, so dropped frames are accepted and leave no trace
// downstream. s_tready falls only when both registers hold data and the result is not
// taken. The decimation exponent is worked out when sample_rate is written, so
// configuration writes must be made while no frame is in flight.
module wav_pcm_to_dac_decimator_top
    import wavdac_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    cfg_we,
    input  logic [CFG_IDX_W-1:0]    cfg_addr,
    input  logic [CFG_DATA_W-1:0]   cfg_wdata,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    // byte_zero [7:0], byte_one [15:8], byte_two [23:16], byte_three [31:24]
    input  logic [S_TDATA_W-1:0]    s_tdata,
    output logic                    m_tvalid,
    input  logic                    m_tready,
    // dac_level [11:0], zero padding [15:12]
    output logic [M_TDATA_W-1:0]    m_tdata
);

    wavdac_fmt_t            fmt_reg;
    logic [SHIFT_W-1:0]     decim_shift_reg;
    logic [COUNT_W-1:0]     skip_count_reg;
    logic [COUNT_W-1:0]     skip_count_next;
    logic                   in_valid_reg;
    logic [S_TDATA_W-1:0]   in_data_reg;
    logic                   out_valid_reg;
    logic [LEVEL_W-1:0]     out_level_reg;
    logic [LEVEL_W-1:0]     level;
    logic [COUNT_W-1:0]     factor;
    logic                   s_beat;
    logic                   keep;
    logic                   out_load_ok;
    logic                   advance;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fmt_reg.sixteen_bit <= 1'b0;
            fmt_reg.stereo      <= 1'b0;
            fmt_reg.volume      <= VOL_RESET;
            decim_shift_reg     <= SHIFT_RESET;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                REG_SIXTEEN_BIT: fmt_reg.sixteen_bit <= cfg_wdata[0];
                REG_STEREO:      fmt_reg.stereo <= cfg_wdata[0];
                REG_VOLUME: begin
                    fmt_reg.volume <= (cfg_wdata[VOL_W-1:0] > MAX_VOL) ?
                                      MAX_VOL : cfg_wdata[VOL_W-1:0];
                end
                REG_SAMPLE_RATE: decim_shift_reg <= decim_shift(cfg_wdata[RATE_W-1:0]);
                default: ;
            endcase
        end
    end

    // Decimation counter.
    assign factor      = COUNT_W'(1) << decim_shift_reg;
    assign out_load_ok = !out_valid_reg || m_tready;
    assign advance     = in_valid_reg && out_load_ok;
    assign s_tready    = !in_valid_reg || out_load_ok;
    assign s_beat      = s_tvalid && s_tready;
    assign keep        = skip_count_reg >= factor;

    always_comb begin
        skip_count_next = skip_count_reg;
        if (s_beat) begin
            skip_count_next = keep ? COUNT_ONE : skip_count_reg + COUNT_ONE;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            skip_count_reg <= COUNT_ONE;
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            skip_count_reg <= skip_count_next;
            if (s_beat) begin
                in_valid_reg <= keep;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (out_load_ok) begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_beat && keep) begin
            in_data_reg <= s_tdata;
        end
        if (advance) begin
            out_level_reg <= level;
        end
    end

    wavdac_level u_level (
        .fmt        (fmt_reg),
        .byte_zero  (in_data_reg[7:0]),
        .byte_one   (in_data_reg[15:8]),
        .byte_two   (in_data_reg[23:16]),
        .byte_three (in_data_reg[31:24]),
        .dac_level  (level)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {(M_TDATA_W-LEVEL_W)'(0), out_level_reg};

    a_count_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        skip_count_reg != '0)
        else $error("decimation counter reached zero");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        skip_count_reg <= COUNT_W'(128))
        else $error("decimation counter beyond largest factor");

    a_in_held: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !out_load_ok |=> in_valid_reg)
        else $error("stalled frame lost from input register");

    a_out_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(in_valid_reg))
        else $error("result raised without a frame in the input register");

endmodule
